FILE: rtl/core/mpeg_audio_header_decode_core_assert.svh
// ----------------------------------------------------------------------------
// MPEG audio header decode assertion macros
// Concurrent assertion wrappers used by the header decode core RTL. The
// checks compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MPEG_AUDIO_HEADER_DECODE_CORE_ASSERT_SVH
`define MPEG_AUDIO_HEADER_DECODE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define MAHD_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mahd: same-cycle check failed");

`define MAHD_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mahd: next-cycle check failed");

`else

`define MAHD_ASSERT_IMPLY(name, clk, rst, ante, cons)

`define MAHD_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/mahd_pkg.sv
// ----------------------------------------------------------------------------
// MPEG audio header decode package
// Word types, header field codes and rate tables for the header decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mahd_pkg;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_VERSION = 3'd1,
    ST_BAD_LAYER   = 3'd2,
    ST_BAD_BITRATE = 3'd3,
    ST_BAD_RATE    = 3'd4,
    ST_FREE_FORMAT = 3'd5
  } status_t;

  // Version field codes in the header.
  localparam logic [1:0] VCODE_MPEG25 = 2'd0;
  localparam logic [1:0] VCODE_MPEG2  = 2'd2;
  localparam logic [1:0] VCODE_MPEG1  = 2'd3;

  // Decoded version numbers.
  localparam logic [1:0] VER_MPEG1  = 2'd0;
  localparam logic [1:0] VER_MPEG2  = 2'd1;
  localparam logic [1:0] VER_MPEG25 = 2'd2;

  localparam logic [1:0] LCODE_RESERVED = 2'd0;
  localparam logic [1:0] CHMODE_MONO    = 2'd3;

  localparam logic [3:0] BIDX_FREE = 4'd0;
  localparam logic [3:0] BIDX_BAD  = 4'd15;

  localparam logic [1:0] SR_IDX_44K      = 2'd0;
  localparam logic [1:0] SR_IDX_48K      = 2'd1;
  localparam logic [1:0] SR_IDX_32K      = 2'd2;
  localparam logic [1:0] SR_IDX_RESERVED = 2'd3;

  localparam int KBPS_ROWS = 5;
  localparam int KBPS_COLS = 16;

  localparam logic [2:0] ROW_MPEG2_L1  = 3'd3;
  localparam logic [2:0] ROW_MPEG2_L23 = 3'd4;

  localparam logic [8:0] KBPS_TABLE [KBPS_ROWS][KBPS_COLS] = '{
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
  };

  localparam logic [15:0] HZ_44K = 16'd44100;
  localparam logic [15:0] HZ_48K = 16'd48000;
  localparam logic [15:0] HZ_32K = 16'd32000;

  // 144000 / 44100 reduces to 160 / 49; 48000 gives 3; 32000 gives 9 / 2.
  localparam int RATE_NUM_44K = 160;
  localparam int RATE_NUM_48K = 3;
  localparam int RATE_NUM_32K = 9;
  localparam int RATE_DIV     = 49;
  localparam int BPS_FACTOR   = 125;

  localparam int NUMER_W     = 17;
  localparam int FRAME_W     = 12;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 19;
  localparam int PROD_W      = NUMER_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_49 = RECIP_W'((2 ** RECIP_SHIFT) / RATE_DIV);

  typedef struct packed {
    logic [31:0] header_word;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  mpeg_version;
    logic [1:0]  layer_number;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic        has_padding;
    logic [1:0]  channel_count;
    logic [11:0] frame_bytes;
    logic [15:0] bytes_per_second;
  } out_word_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  ver;
    logic [1:0]  layer;
    logic [8:0]  kbps;
    logic [15:0] hz;
    logic        pad;
    logic [1:0]  chans;
    logic [1:0]  sidx;
  } hdr_t;

  typedef struct packed {
    hdr_t               hdr;
    logic [NUMER_W-1:0] numer;
    logic               use_div;
    logic [15:0]        bps;
  } scaled_t;

  typedef struct packed {
    scaled_t            sc;
    logic [FRAME_W-1:0] q_est;
  } recip_t;

  function automatic logic [15:0] hz_base(input logic [1:0] sidx);
    logic [15:0] hz;
    unique case (sidx)
      SR_IDX_44K: hz = HZ_44K;
      SR_IDX_48K: hz = HZ_48K;
      SR_IDX_32K: hz = HZ_32K;
      default:    hz = 16'd0;
    endcase
    return hz;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mahd_stream_if.sv
// ----------------------------------------------------------------------------
// MPEG audio header decode stream interface
// Valid/ready channel that carries one word of the given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface mahd_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

FILE: rtl/core/mahd_decode.sv
// ----------------------------------------------------------------------------
// MPEG audio header decode field stage
// Splits the header word, looks up bitrate and sample rate and sets status.
// ----------------------------------------------------------------------------
`default_nettype none

module mahd_decode (
  input  wire logic    clk,
  input  wire logic    rst,
  mahd_stream_if.sink  hdr,
  mahd_stream_if.source dec
);

  logic              valid;
  mahd_pkg::hdr_t    word;
  mahd_pkg::hdr_t    word_next;

  logic [1:0] vcode;
  logic [1:0] lcode;
  logic [3:0] bidx;
  logic       ver_ok;
  logic [2:0] row;

  assign hdr.ready = !valid || dec.ready;
  assign dec.valid = valid;
  assign dec.data  = word;

  always_comb begin
    vcode = hdr.data.header_word[20:19];
    lcode = hdr.data.header_word[18:17];
    bidx  = hdr.data.header_word[15:12];

    word_next       = '0;
    word_next.sidx  = hdr.data.header_word[11:10];
    word_next.pad   = hdr.data.header_word[9];
    word_next.chans = (hdr.data.header_word[7:6] == mahd_pkg::CHMODE_MONO) ? 2'd1 : 2'd2;
    word_next.layer = (lcode == mahd_pkg::LCODE_RESERVED) ? 2'd0 : 2'(3'd4 - {1'b0, lcode});

    ver_ok = 1'b1;
    unique case (vcode)
      mahd_pkg::VCODE_MPEG1:  word_next.ver = mahd_pkg::VER_MPEG1;
      mahd_pkg::VCODE_MPEG2:  word_next.ver = mahd_pkg::VER_MPEG2;
      mahd_pkg::VCODE_MPEG25: word_next.ver = mahd_pkg::VER_MPEG25;
      default: begin
        word_next.ver = mahd_pkg::VER_MPEG1;
        ver_ok        = 1'b0;
      end
    endcase

    priority if (word_next.ver == mahd_pkg::VER_MPEG1) begin
      row = 3'(word_next.layer - 2'd1);
    end else if (word_next.ver == mahd_pkg::VER_MPEG2 && word_next.layer == 2'd1) begin
      row = mahd_pkg::ROW_MPEG2_L1;
    end else begin
      row = mahd_pkg::ROW_MPEG2_L23;
    end

    if (ver_ok) begin
      word_next.hz = mahd_pkg::hz_base(word_next.sidx) >> word_next.ver;
      if (word_next.layer != 2'd0) begin
        word_next.kbps = mahd_pkg::KBPS_TABLE[row][bidx];
      end
    end

    priority if (!ver_ok) begin
      word_next.status = mahd_pkg::ST_BAD_VERSION;
    end else if (word_next.layer == 2'd0) begin
      word_next.status = mahd_pkg::ST_BAD_LAYER;
    end else if (bidx == mahd_pkg::BIDX_BAD) begin
      word_next.status = mahd_pkg::ST_BAD_BITRATE;
    end else if (word_next.sidx == mahd_pkg::SR_IDX_RESERVED) begin
      word_next.status = mahd_pkg::ST_BAD_RATE;
    end else if (bidx == mahd_pkg::BIDX_FREE) begin
      word_next.status = mahd_pkg::ST_FREE_FORMAT;
    end else begin
      word_next.status = mahd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (hdr.ready) begin
      valid <= hdr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr.valid && hdr.ready) begin
      word <= word_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mahd_scale.sv
// ----------------------------------------------------------------------------
// MPEG audio header decode scaling stage
// Forms the frame length numerator for the sample rate family and the
// byte rate.
// ----------------------------------------------------------------------------
`default_nettype none

module mahd_scale (
  input  wire logic    clk,
  input  wire logic    rst,
  mahd_stream_if.sink  dec,
  mahd_stream_if.source scl
);

  localparam int NW = mahd_pkg::NUMER_W;

  logic              valid;
  mahd_pkg::scaled_t word;
  mahd_pkg::scaled_t word_next;

  logic [NW-1:0] kbps_w;
  logic [NW-1:0] numer_32k;

  assign dec.ready = !valid || scl.ready;
  assign scl.valid = valid;
  assign scl.data  = word;

  always_comb begin
    kbps_w          = NW'(dec.data.kbps);
    numer_32k       = (NW'(kbps_w * NW'(mahd_pkg::RATE_NUM_32K)) << dec.data.ver) >> 1;
    word_next       = '0;
    word_next.hdr   = dec.data;
    word_next.bps   = 16'(dec.data.kbps * 16'(mahd_pkg::BPS_FACTOR));
    unique case (dec.data.sidx)
      mahd_pkg::SR_IDX_44K: begin
        word_next.numer   = NW'(kbps_w * NW'(mahd_pkg::RATE_NUM_44K)) << dec.data.ver;
        word_next.use_div = 1'b1;
      end
      mahd_pkg::SR_IDX_48K: begin
        word_next.numer   = NW'(kbps_w * NW'(mahd_pkg::RATE_NUM_48K)) << dec.data.ver;
        word_next.use_div = 1'b0;
      end
      mahd_pkg::SR_IDX_32K: begin
        word_next.numer   = numer_32k;
        word_next.use_div = 1'b0;
      end
      default: begin
        word_next.numer   = '0;
        word_next.use_div = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (dec.ready) begin
      valid <= dec.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dec.valid && dec.ready) begin
      word <= word_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mahd_recip.sv
// ----------------------------------------------------------------------------
// MPEG audio header decode divide stage
// Divides the 44.1 kHz family numerator by 49 with a reciprocal multiply
// and one correction step, then assembles the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module mahd_recip (
  input  wire logic    clk,
  input  wire logic    rst,
  mahd_stream_if.sink  scl,
  mahd_stream_if.source res
);

  localparam int NW = mahd_pkg::NUMER_W;
  localparam int FW = mahd_pkg::FRAME_W;

  logic                       mul_valid;
  logic                       mul_ready;
  mahd_pkg::recip_t           mul_word;
  logic [mahd_pkg::PROD_W-1:0] prod;

  logic                 out_valid;
  mahd_pkg::out_word_t  out_word;
  mahd_pkg::out_word_t  out_word_next;
  logic [NW-1:0]        rem;
  logic [FW-1:0]        quot;
  logic [FW-1:0]        frame;

  assign prod      = mahd_pkg::PROD_W'(scl.data.numer) * mahd_pkg::PROD_W'(mahd_pkg::RECIP_49);
  assign mul_ready = !out_valid || res.ready;
  assign scl.ready = !mul_valid || mul_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (scl.ready) begin
      mul_valid <= scl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scl.valid && scl.ready) begin
      mul_word.sc    <= scl.data;
      mul_word.q_est <= prod[mahd_pkg::RECIP_SHIFT +: FW];
    end
  end

  always_comb begin
    rem  = mul_word.sc.numer - NW'(NW'(mul_word.q_est) * NW'(mahd_pkg::RATE_DIV));
    quot = (rem >= NW'(mahd_pkg::RATE_DIV)) ? mul_word.q_est + FW'(1) : mul_word.q_est;
    frame = mul_word.sc.use_div ? quot : mul_word.sc.numer[FW-1:0];

    out_word_next                  = '0;
    out_word_next.status           = mul_word.sc.hdr.status;
    out_word_next.mpeg_version     = mul_word.sc.hdr.ver;
    out_word_next.layer_number     = mul_word.sc.hdr.layer;
    out_word_next.bitrate_kbps     = mul_word.sc.hdr.kbps;
    out_word_next.sample_rate_hz   = mul_word.sc.hdr.hz;
    out_word_next.has_padding      = mul_word.sc.hdr.pad;
    out_word_next.channel_count    = mul_word.sc.hdr.chans;
    out_word_next.bytes_per_second = mul_word.sc.bps;
    if (mul_word.sc.hdr.status == mahd_pkg::ST_OK) begin
      out_word_next.frame_bytes = frame + FW'(mul_word.sc.hdr.pad);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mul_ready) begin
      out_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_valid && mul_ready) begin
      out_word <= out_word_next;
    end
  end

  assign res.valid = out_valid;
  assign res.data  = out_word;

endmodule

`default_nettype wire

FILE: rtl/core/mpeg_audio_header_decode_core.sv
// ----------------------------------------------------------------------------
// MPEG audio header decode core
// Throughput: one header word per cycle while the output is not stalled.
// The four register stages are field decode, numerator scaling, reciprocal
// multiply and correction.
// Each stage holds its word under backpressure and frees as its successor takes it.
// Reset: synchronous active-high rst clears all stage valid flags only.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mpeg_audio_header_decode_core_assert.svh"

module mpeg_audio_header_decode_core (
  input  wire logic     clk,
  input  wire logic     rst,
  mahd_stream_if.sink   hdr,
  mahd_stream_if.source res
);

  mahd_stream_if #(.payload_t(mahd_pkg::hdr_t))    dec ();
  mahd_stream_if #(.payload_t(mahd_pkg::scaled_t)) scl ();

  mahd_decode u_decode (
    .clk (clk),
    .rst (rst),
    .hdr (hdr),
    .dec (dec)
  );

  mahd_scale u_scale (
    .clk (clk),
    .rst (rst),
    .dec (dec),
    .scl (scl)
  );

  mahd_recip u_recip (
    .clk (clk),
    .rst (rst),
    .scl (scl),
    .res (res)
  );

  `MAHD_ASSERT_NEXT(a_accept_lands, clk, rst, hdr.valid && hdr.ready, dec.valid)
  `MAHD_ASSERT_IMPLY(a_fault_no_frame, clk, rst,
                     res.valid && res.data.status != mahd_pkg::ST_OK,
                     res.data.frame_bytes == 12'd0)
  `MAHD_ASSERT_IMPLY(a_ok_has_frame, clk, rst,
                     res.valid && res.data.status == mahd_pkg::ST_OK,
                     res.data.frame_bytes != 12'd0 && res.data.sample_rate_hz != 16'd0)
  `MAHD_ASSERT_IMPLY(a_byte_rate, clk, rst, res.valid,
                     res.data.bytes_per_second ==
                     16'(res.data.bitrate_kbps * 16'(mahd_pkg::BPS_FACTOR)))

endmodule

`default_nettype wire
